### design/ali_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ali_pkg;

  // Store geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int TALLY_W     = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_BITS   = OP_W + ADDR_W + DATA_W;
  localparam int IN_DW     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + DATA_W + CNT_W + TALLY_W;
  localparam int OUT_DW    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MOVE = 2'b10
  } state_t;

endpackage

`default_nettype wire

### design/ali_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ali_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/array_list_insert_delete.sv
// Errors, full inserts and clear: the result is registered at the request edge.
// Read: the target value is fetched from the list RAM. Delete or insert below the tail:
// one element move per cycle through the list RAM. An insert at the tail moves nothing.
// One request is in work at a time; the next is taken once the result register is free.
// Reset (rst_n low, synchronous) empties the list, zeroes the move tally and sets the
// capacity to 256; the RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module array_list_insert_delete
  import ali_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request stream. tdata from bit 0: operation[1:0], position[9:2], item_value[41:10].
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,
  // Result stream. tdata from bit 0: status[1:0], data_out[33:2], entry_count[42:34],
  // shift_total[74:43].
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,
  // Capacity register write.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  // Request fields.
  op_t               in_op;
  logic [ADDR_W-1:0] in_pos;
  logic [DATA_W-1:0] in_val;

  assign in_op  = op_t'(in_tdata[OP_W-1:0]);
  assign in_pos = in_tdata[OP_W +: ADDR_W];
  assign in_val = in_tdata[OP_W+ADDR_W +: DATA_W];

  // Control and architectural state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [CNT_W-1:0]   cap_r;

  // Move sequencer: rd_ptr_r is the next RAM address to read, ctr_r the reads left.
  // A read issued in one cycle returns its data in the next, where pend_r marks it
  // and pend_addr_r gives the slot it moves into. skip_r marks the first read of a
  // read or delete, which fetches the target value instead of moving anything.
  op_t                op_r, op_nxt;
  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [ADDR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   ctr_r, ctr_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic               skip_r, skip_nxt;
  logic [DATA_W-1:0]  data_r, data_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  logic [CNT_W-1:0]    res_count_r, res_count_nxt;
  logic [TALLY_W-1:0]  res_tally_r, res_tally_nxt;

  // RAM ports.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  ram_rdata;

  logic               in_fire;
  logic               move_done;
  logic [CNT_W-1:0]   eff_cap;
  logic [CNT_W-1:0]   pos_ext;

  // Capacity above the store size is limited to the store size.
  assign eff_cap = (cap_r > MAX_CNT) ? MAX_CNT : cap_r;
  assign pos_ext = {1'b0, in_pos};

  // A request is taken only from idle, and only when the result register is free
  // or is being emptied on this same edge.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Sequencer is finished once no read is left to issue and none is in flight.
  assign move_done = (state_r == S_MOVE) && (ctr_r == '0) && !pend_r;

  // The write port either moves a fetched element or, at the end of an insert,
  // places the new value in the freed slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = ram_rdata;
    if ((state_r == S_MOVE) && pend_r && !skip_r) begin
      ram_we = 1'b1;
    end else if (move_done && (op_r == OP_INSERT)) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = val_r;
    end
  end

  ali_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    tally_nxt      = tally_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    rd_ptr_nxt     = rd_ptr_r;
    ctr_nxt        = ctr_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    skip_nxt       = skip_r;
    data_nxt       = data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_count_nxt  = res_count_r;
    res_tally_nxt  = res_tally_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_op;
          pos_nxt  = in_pos;
          val_nxt  = in_val;
          data_nxt = '0;
          // Default result for the cases that finish on the request edge.
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_count_nxt  = occ_r;
          res_tally_nxt  = tally_r;
          unique case (in_op)
            OP_READ, OP_DELETE: begin
              if (pos_ext >= occ_r) begin
                res_status_nxt = ST_INDEX;
                out_valid_nxt  = 1'b1;
              end else begin
                // Fetch the target first, then (delete only) pull the tail down.
                rd_ptr_nxt = in_pos;
                ctr_nxt    = (in_op == OP_READ) ? CNT_W'(1) : (occ_r - pos_ext);
                skip_nxt   = 1'b1;
                state_nxt  = S_MOVE;
              end
            end
            OP_INSERT: begin
              if (pos_ext > occ_r) begin
                res_status_nxt = ST_INDEX;
                out_valid_nxt  = 1'b1;
              end else if (occ_r >= eff_cap) begin
                res_status_nxt = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                // Move the tail up starting from the top entry.
                rd_ptr_nxt = ADDR_W'(occ_r - CNT_W'(1));
                ctr_nxt    = occ_r - pos_ext;
                skip_nxt   = 1'b0;
                state_nxt  = S_MOVE;
              end
            end
            OP_CLEAR: begin
              occ_nxt       = '0;
              tally_nxt     = '0;
              res_count_nxt = '0;
              res_tally_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_MOVE: begin
        // Retire the read issued last cycle.
        if (pend_r) begin
          if (skip_r) begin
            data_nxt = ram_rdata;
            skip_nxt = 1'b0;
          end else begin
            tally_nxt = tally_r + TALLY_W'(1);
          end
        end
        // Issue the next read. Insert walks down and writes one slot higher;
        // delete walks up and writes one slot lower. The target fetch of a
        // read or delete has no write, so its slot is never used.
        if (ctr_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = (op_r == OP_INSERT) ? (rd_ptr_r + ADDR_W'(1))
                                              : (rd_ptr_r - ADDR_W'(1));
          rd_ptr_nxt    = (op_r == OP_INSERT) ? (rd_ptr_r - ADDR_W'(1))
                                              : (rd_ptr_r + ADDR_W'(1));
          ctr_nxt       = ctr_r - CNT_W'(1);
        end
        if (move_done) begin
          unique case (op_r)
            OP_INSERT: occ_nxt = occ_r + CNT_W'(1);
            OP_DELETE: occ_nxt = occ_r - CNT_W'(1);
            default:   occ_nxt = occ_r;
          endcase
          res_status_nxt = ST_OK;
          res_data_nxt   = data_r;
          res_count_nxt  = occ_nxt;
          res_tally_nxt  = tally_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      tally_r     <= '0;
      cap_r       <= CAP_RESET;
      pend_r      <= 1'b0;
      skip_r      <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      tally_r     <= tally_nxt;
      pend_r      <= pend_nxt;
      skip_r      <= skip_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    pend_addr_r  <= pend_addr_nxt;
    data_r       <= data_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_count_r  <= res_count_nxt;
    res_tally_r  <= res_tally_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({res_tally_r, res_count_r, res_data_r, res_status_r});

  // The list never holds more entries than the store.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= MAX_CNT)
    else $error("occupancy exceeds the store size");

  // The RAM is never written while no request is in work.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  // A read issued while moving is retired in the next cycle.
  a_read_retires: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MOVE) && (ctr_r != '0)) |=> pend_r)
    else $error("issued read not retired");

  // The tally only steps with an element move, or returns to zero on clear.
  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (tally_r != $past(tally_r))) |->
      (($past(ram_we) && (tally_r == $past(tally_r) + TALLY_W'(1))) || (tally_r == '0)))
    else $error("move tally changed without a move");

  // Occupancy only changes at the request edge or when a move sequence ends.
  a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (occ_r != $past(occ_r))) |-> ($past(in_fire) || $past(move_done)))
    else $error("occupancy changed outside a request");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the array list block. Requests go in on the in_ stream and
// each one is applied to a behavioral copy of the list here, which yields the reply
// the block must return. Replies are checked in order on the out_ stream. Directed
// tests cover the empty list, shifting, clear, capacity corners and a completely full
// store. A long random run follows, with bursty requests and a stalling receiver.
module testbench;
  import ali_pkg::*;

  // One reply of the block, in unpacked form.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [CNT_W-1:0]    count;
    logic [TALLY_W-1:0]  tally;
  } list_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // Fields from bit 0: operation, position, item_value, zero padding.
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // Fields from bit 0: status, data_out, entry_count, shift_total, zero padding.
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  // Behavioral copy of the list and of the capacity register.
  logic [DATA_W-1:0]  list_words [MAX_ENTRIES];
  int                 list_len = 0;
  logic [TALLY_W-1:0] move_count = '0;
  logic [CNT_W-1:0]   cap_reg = CAP_RESET;

  // Replies predicted for accepted requests, oldest first.
  list_reply_t pending_replies [$];

  int  err_count = 0;
  int  burst_left = 0;
  bit  req_up = 1'b0;
  bit  steady_stream = 1'b0;
  time req_drop_time = -1;
  time cfg_drop_time = -1;

  array_list_insert_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one request to the list copy and returns the reply it must produce.
  function automatic list_reply_t run_list_op(op_t op, logic [ADDR_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
    list_reply_t r;
    int limit;
    int idx;
    r.status = ST_OK;
    r.data = '0;
    // Register values above the store size act as the store size.
    limit = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
    case (op)
      OP_READ: begin
        if (pos >= list_len) r.status = ST_INDEX;
        else r.data = list_words[pos];
      end
      OP_INSERT: begin
        // The index check wins over the full check.
        if (pos > list_len) begin
          r.status = ST_INDEX;
        end else if (list_len >= limit) begin
          r.status = ST_FULL;
        end else begin
          for (idx = list_len; idx > pos; idx--) begin
            list_words[idx] = list_words[idx - 1];
            move_count = move_count + 1'b1;
          end
          list_words[pos] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= list_len) begin
          r.status = ST_INDEX;
        end else begin
          r.data = list_words[pos];
          for (idx = pos; idx + 1 < list_len; idx++) begin
            list_words[idx] = list_words[idx + 1];
            move_count = move_count + 1'b1;
          end
          list_len--;
        end
      end
      default: begin
        list_len = 0;
        move_count = '0;
      end
    endcase
    r.count = CNT_W'(list_len);
    r.tally = move_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
    $display("MISMATCH at %0t ns: %s expected %h got %h", $time, what, want, got);
    err_count++;
  endtask

  // Offers one request and waits for it to be taken. Requests come in bursts; a new
  // burst may start after a random gap with the valid low.
  task automatic send_request(op_t op, logic [ADDR_W-1:0] pos, logic [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = (steady_stream || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0 && req_up) begin
        in_tvalid <= 1'b0;
        req_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
      if (steady_stream) burst_left = $urandom_range(60, 120);
      else if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 80);
      else burst_left = $urandom_range(1, 10);
    end
    // The valid must not fall and rise within the same step.
    if (req_drop_time == $time) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DW - IN_BITS){1'b0}}, val, pos, op};
    req_up = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(run_list_op(op, pos, val));
    burst_left--;
  endtask

  // Drops the request valid so that nothing stale is taken while the bench waits.
  task automatic hold_requests();
    if (req_up) begin
      in_tvalid <= 1'b0;
      req_up = 1'b0;
      req_drop_time = $time;
    end
    burst_left = 0;
  endtask

  task automatic wait_for_results();
    hold_requests();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Every request yields a reply, so the block is idle once nothing is pending.
  task automatic set_capacity(logic [CNT_W-1:0] cap);
    wait_for_results();
    if (cfg_drop_time == $time) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_drop_time = $time;
    cap_reg = cap;
  endtask

  // Receiver: switches between always ready, coin flips, mostly stalled and
  // occasional long stalls, with a new mode picked at random when the last one ends.
  int ready_mode = 0;
  int mode_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 400);
    end
    mode_left--;
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 20);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Reply checker: every taken reply is compared with the oldest prediction.
  always @(posedge clk) begin : check_reply
    list_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request waiting, data_out", '0, out_tdata[33:2]);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", DATA_W'(want.status), DATA_W'(out_tdata[1:0]));
        if (out_tdata[33:2] !== want.data)
          report_mismatch("data_out", want.data, out_tdata[33:2]);
        if (out_tdata[42:34] !== want.count)
          report_mismatch("entry_count", DATA_W'(want.count), DATA_W'(out_tdata[42:34]));
        if (out_tdata[74:43] !== want.tally)
          report_mismatch("shift_total", want.tally, out_tdata[74:43]);
      end
    end
  end

  // After reset the list is empty, so every indexed access except an insert at the
  // head must report an index error.
  task automatic test_empty_list();
    send_request(OP_READ, 8'd0, 32'h0);
    send_request(OP_DELETE, 8'd0, 32'h0);
    send_request(OP_INSERT, 8'd1, 32'h1234_5678);
    send_request(OP_READ, 8'd255, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 8'd255, 32'h0);
    wait_for_results();
  endtask

  // Inserts at the head, middle and end with extreme values, then reads and deletes
  // so that the shift direction and move count are visible.
  task automatic test_shift_order();
    int i;
    send_request(OP_INSERT, 8'd0, 32'h8000_0000);
    send_request(OP_INSERT, 8'd0, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 8'd2, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'd1, 32'h0000_0000);
    send_request(OP_INSERT, 8'd4, 32'h5A5A_A5A5);
    for (i = 0; i < 6; i++) send_request(OP_READ, ADDR_W'(i), 32'h0);
    send_request(OP_INSERT, 8'd7, 32'h1);
    send_request(OP_DELETE, 8'd2, 32'h0);
    send_request(OP_DELETE, 8'd3, 32'h0);
    send_request(OP_DELETE, 8'd0, 32'h0);
    send_request(OP_READ, 8'd0, 32'h0);
    send_request(OP_READ, 8'd1, 32'h0);
    wait_for_results();
  endtask

  // Clear ignores its position and value and zeroes both the list and the tally.
  task automatic test_clear();
    send_request(OP_CLEAR, 8'd255, 32'hFFFF_FFFF);
    send_request(OP_READ, 8'd0, 32'h0);
    send_request(OP_INSERT, 8'd0, 32'hDEAD_BEEF);
    send_request(OP_CLEAR, 8'd0, 32'h0);
    wait_for_results();
  endtask

  // Small, zero and lowered capacities, including a capacity below the occupancy.
  task automatic test_capacity_limits();
    set_capacity(9'd2);
    send_request(OP_INSERT, 8'd0, 32'h0000_0011);
    send_request(OP_INSERT, 8'd1, 32'h0000_0022);
    send_request(OP_INSERT, 8'd0, 32'h0000_0033);
    send_request(OP_INSERT, 8'd5, 32'h0000_0044);
    set_capacity(9'd0);
    send_request(OP_INSERT, 8'd0, 32'h0000_0055);
    send_request(OP_READ, 8'd1, 32'h0);
    set_capacity(9'd1);
    send_request(OP_READ, 8'd1, 32'h0);
    send_request(OP_INSERT, 8'd2, 32'h0000_0066);
    send_request(OP_DELETE, 8'd0, 32'h0);
    send_request(OP_INSERT, 8'd0, 32'h0000_0077);
    send_request(OP_DELETE, 8'd0, 32'h0);
    send_request(OP_INSERT, 8'd0, 32'h0000_0088);
    send_request(OP_READ, 8'd0, 32'h0);
    send_request(OP_CLEAR, 8'd0, 32'h0);
    wait_for_results();
  endtask

  // Fills the whole store at the largest legal capacity, then checks that a register
  // value above the store size still stops at the store size.
  task automatic test_full_store();
    logic [ADDR_W-1:0] pos;
    set_capacity(9'd256);
    while (list_len < MAX_ENTRIES) begin
      pos = (list_len > 255) ? 8'd255 : ADDR_W'($urandom_range(0, list_len));
      send_request(OP_INSERT, pos, $urandom);
    end
    send_request(OP_INSERT, 8'd255, 32'h0);
    send_request(OP_READ, 8'd255, 32'h0);
    set_capacity(9'd511);
    send_request(OP_INSERT, 8'd0, 32'h0);
    send_request(OP_DELETE, 8'd255, 32'h0);
    send_request(OP_DELETE, 8'd0, 32'h0);
    send_request(OP_INSERT, 8'd254, 32'hCAFE_F00D);
    send_request(OP_INSERT, 8'd0, 32'h0);
    send_request(OP_READ, 8'd254, 32'h0);
    send_request(OP_CLEAR, 8'd17, 32'h0);
    wait_for_results();
  endtask

  // One random request. Most positions are in range so the list grows and shrinks;
  // the rest are fully random and mostly give index errors.
  task automatic random_request(int ins_pct);
    int pick;
    op_t op;
    logic [ADDR_W-1:0] pos;
    int top;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) op = OP_INSERT;
    else if (pick < ins_pct + (96 - ins_pct) / 2) op = OP_DELETE;
    else if (pick < 97) op = OP_READ;
    else op = OP_CLEAR;
    top = (op == OP_INSERT) ? list_len : list_len - 1;
    if (top > 255) top = 255;
    pick = $urandom_range(0, 9);
    if (pick < 2 || top < 0) pos = ADDR_W'($urandom_range(0, 255));
    else if (pick == 2) pos = 8'd0;
    else if (pick == 3) pos = ADDR_W'(top);
    else pos = ADDR_W'($urandom_range(0, top));
    send_request(op, pos, $urandom);
  endtask

  task automatic test_random_traffic();
    int caps [10];
    int counts [10];
    int ins [10];
    int p;
    int n;
    caps = '{8, 1, 256, 0, 300, 2, 16, 511, 32, 256};
    counts = '{150, 100, 200, 60, 120, 160, 160, 160, 160, 160};
    ins = '{45, 45, 65, 40, 40, 50, 55, 35, 50, 45};
    caps[5] = $urandom_range(2, 64);
    for (p = 0; p < 10; p++) begin
      set_capacity(CNT_W'(caps[p]));
      steady_stream = (p == 6);
      for (n = 0; n < counts[p]; n++) begin
        random_request(ins[p]);
        // Let the block drain completely once in the middle of a phase.
        if (p == 2 && n == counts[p] / 2) wait_for_results();
      end
    end
    steady_stream = 1'b0;
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_shift_order();
    test_clear();
    test_capacity_limits();
    test_full_store();
    test_random_traffic();
    wait_for_results();
    // A stray reply could still follow the longest shift.
    repeat (300) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### array_list_insert_delete.f
design/ali_pkg.sv
design/ali_ram.sv
design/array_list_insert_delete.sv
tb/sv/testbench.sv
